FILE: hw/rtl/vfg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfg_pkg
// Shared types and constants of the voice activity frame gate.
// ----------------------------------------------------------------------------
package vfg_pkg;

   localparam int HOLD_DEPTH_DEF = 32;
   localparam int DATA_BITS_DEF  = 32;
   localparam int CNT_MAX_BITS   = 6;
   localparam int QUEUE_DEPTH    = 4;
   localparam int CSR_IDX_BITS   = 2;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [1:0] {
      VAD_SIL_CONF    = 2'd0,
      VAD_SPEECH_TRIG = 2'd1,
      VAD_SPEECH_CONF = 2'd2,
      VAD_SIL_TRIG    = 2'd3
   } vad_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ENABLED        = 2'd0,
      CSR_REMOVE_SILENCE = 2'd1,
      CSR_SEGMENTING     = 2'd2
   } csr_index_type;

   // one emission job: optional delayed word, then buffer entries start..stop-1
   typedef struct packed {
      logic                    has_delay;
      logic                    seg;
      logic [CNT_MAX_BITS-1:0] start;
      logic [CNT_MAX_BITS-1:0] stop;
   } cmd_ctl_type;

endpackage
`default_nettype wire

FILE: hw/rtl/vfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfg_if
// Handshake channels of the voice activity frame gate.
// ----------------------------------------------------------------------------
interface vfg_req_if #(parameter int DATA_BITS = vfg_pkg::DATA_BITS_DEF);
   logic                 valid;
   logic                 ready;
   logic [1:0]           vad_state;
   logic [DATA_BITS-1:0] frame_data;
   logic                 end_of_data;
   modport source (output valid, vad_state, frame_data, end_of_data, input ready);
   modport sink   (input valid, vad_state, frame_data, end_of_data, output ready);
endinterface

interface vfg_rsp_if #(parameter int DATA_BITS = vfg_pkg::DATA_BITS_DEF);
   logic                 valid;
   logic                 ready;
   logic [DATA_BITS-1:0] out_data;
   logic                 segment_end;
   logic                 last;
   modport source (output valid, out_data, segment_end, last, input ready);
   modport sink   (input valid, out_data, segment_end, last, output ready);
endinterface

interface vfg_csr_if;
   logic                               valid;
   logic                               ready;
   logic [vfg_pkg::CSR_IDX_BITS-1:0]   index;
   logic [vfg_pkg::CSR_DATA_BITS-1:0]  wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/vfg_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfg_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module vfg_ram #(
   parameter int WIDTH = vfg_pkg::DATA_BITS_DEF,
   parameter int DEPTH = vfg_pkg::HOLD_DEPTH_DEF,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/vfg_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfg_queue
// Small command queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
module vfg_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = vfg_pkg::QUEUE_DEPTH,
   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic      [WIDTH-1:0] pop_data
);

   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [PW-1:0] PTR_ONE  = PW'(1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
   localparam logic [CW-1:0] CNT_ONE  = CW'(1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == CNT_FULL);
   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_ONE;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/vfg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfg_front
// Accepts frames, tracks the gate phase, fills the hold buffer and
// queues emission commands. Also holds the configuration registers.
// ----------------------------------------------------------------------------
module vfg_front #(
   parameter int HOLD_DEPTH = vfg_pkg::HOLD_DEPTH_DEF,
   parameter int DATA_BITS  = vfg_pkg::DATA_BITS_DEF,
   localparam int AW        = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   vfg_req_if.sink                   req,
   vfg_csr_if.sink                   csr,
   output logic                      mem_wr_en,
   output logic [AW-1:0]             mem_wr_addr,
   output logic [DATA_BITS-1:0]      mem_wr_data,
   output logic                      cmd_push,
   output vfg_pkg::cmd_ctl_type      cmd_ctl,
   output logic [DATA_BITS-1:0]      cmd_data,
   input  wire logic                 queue_full,
   input  wire logic                 flush_done
);

   localparam int CNT_BITS = $clog2(HOLD_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(HOLD_DEPTH);
   localparam logic [CNT_BITS-1:0] CNT_ONE   = CNT_BITS'(1);

   vfg_pkg::vad_type       phase_ff, phase_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic                   stopped_ff, stopped_in;
   logic                   busy_ff, busy_in;
   logic [DATA_BITS-1:0]   delay_ff, delay_in;
   logic                   enabled_ff, rm_sil_ff, segmenting_ff;
   logic                   accept;
   vfg_pkg::vad_type       vad;

   assign req.ready = !busy_ff && !queue_full;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;
   assign vad       = vfg_pkg::vad_type'(req.vad_state);

   always_comb begin
      phase_in          = phase_ff;
      count_in          = count_ff;
      stopped_in        = stopped_ff;
      busy_in           = busy_ff;
      delay_in          = delay_ff;
      mem_wr_en         = 1'b0;
      mem_wr_addr       = count_ff[AW-1:0];
      mem_wr_data       = req.frame_data;
      cmd_push          = 1'b0;
      cmd_data          = delay_ff;
      cmd_ctl.has_delay = 1'b1;
      cmd_ctl.seg       = 1'b0;
      cmd_ctl.start     = '0;
      cmd_ctl.stop      = '0;

      if (flush_done) begin
         busy_in = 1'b0;
      end

      if (accept) begin
         if (req.end_of_data) begin
            if (phase_ff == vfg_pkg::VAD_SPEECH_CONF || phase_ff == vfg_pkg::VAD_SIL_TRIG) begin
               cmd_push    = 1'b1;
               cmd_ctl.seg = 1'b1;
            end
            count_in = '0;
            phase_in = vfg_pkg::VAD_SIL_CONF;
         end else if (!enabled_ff) begin
            cmd_push = 1'b1;
            cmd_data = req.frame_data;
         end else if (!stopped_ff) begin
            unique case (phase_ff)
               vfg_pkg::VAD_SIL_CONF: begin
                  if (vad == vfg_pkg::VAD_SPEECH_TRIG) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = '0;
                     count_in    = CNT_ONE;
                     phase_in    = vfg_pkg::VAD_SPEECH_TRIG;
                  end
               end
               vfg_pkg::VAD_SPEECH_TRIG: begin
                  if (vad == vfg_pkg::VAD_SPEECH_TRIG) begin
                     if (count_ff < DEPTH_CNT) begin
                        mem_wr_en = 1'b1;
                        count_in  = count_ff + CNT_ONE;
                     end
                  end else if (vad == vfg_pkg::VAD_SPEECH_CONF) begin
                     cmd_push          = 1'b1;
                     cmd_ctl.has_delay = 1'b0;
                     cmd_ctl.stop      = vfg_pkg::CNT_MAX_BITS'(count_ff);
                     busy_in           = 1'b1;
                     delay_in          = req.frame_data;
                     count_in          = CNT_ONE;
                     phase_in          = vfg_pkg::VAD_SPEECH_CONF;
                  end else begin
                     count_in = '0;
                     phase_in = vfg_pkg::VAD_SIL_CONF;
                  end
               end
               vfg_pkg::VAD_SPEECH_CONF, vfg_pkg::VAD_SIL_TRIG: begin
                  if (vad == vfg_pkg::VAD_SIL_TRIG) begin
                     if (count_ff < DEPTH_CNT) begin
                        mem_wr_en = 1'b1;
                        count_in  = count_ff + CNT_ONE;
                     end
                     phase_in = vfg_pkg::VAD_SIL_TRIG;
                  end else if (vad == vfg_pkg::VAD_SPEECH_CONF ||
                               (vad == vfg_pkg::VAD_SPEECH_TRIG &&
                                phase_ff == vfg_pkg::VAD_SPEECH_CONF)) begin
                     // flush held silence after the delayed word
                     cmd_push      = 1'b1;
                     cmd_ctl.start = vfg_pkg::CNT_MAX_BITS'(1);
                     cmd_ctl.stop  = vfg_pkg::CNT_MAX_BITS'(count_ff);
                     busy_in       = (count_ff > CNT_ONE);
                     delay_in      = req.frame_data;
                     count_in      = CNT_ONE;
                     phase_in      = vfg_pkg::VAD_SPEECH_CONF;
                  end else begin
                     // segment end
                     cmd_push    = 1'b1;
                     cmd_ctl.seg = !rm_sil_ff;
                     count_in    = '0;
                     phase_in    = vfg_pkg::VAD_SIL_CONF;
                     if (!rm_sil_ff && !segmenting_ff) begin
                        stopped_in = 1'b1;
                     end
                  end
               end
               default: begin
                  phase_in = vfg_pkg::VAD_SIL_CONF;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= vfg_pkg::VAD_SIL_CONF;
         count_ff      <= '0;
         stopped_ff    <= 1'b0;
         busy_ff       <= 1'b0;
         enabled_ff    <= 1'b1;
         rm_sil_ff     <= 1'b0;
         segmenting_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
         busy_ff    <= busy_in;
         if (csr.valid && csr.ready) begin
            unique case (csr.index)
               vfg_pkg::CSR_ENABLED:        enabled_ff    <= csr.wdata[0];
               vfg_pkg::CSR_REMOVE_SILENCE: rm_sil_ff     <= csr.wdata[0];
               vfg_pkg::CSR_SEGMENTING:     segmenting_ff <= csr.wdata[0];
               default: ;
            endcase
         end
      end
      delay_ff <= delay_in;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/vfg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfg_back
// Executes emission commands: the optional delayed word, then a run of hold
// buffer reads, one result per cycle into the output register unless the output stalls.
// ----------------------------------------------------------------------------
module vfg_back #(
   parameter int HOLD_DEPTH = vfg_pkg::HOLD_DEPTH_DEF,
   parameter int DATA_BITS  = vfg_pkg::DATA_BITS_DEF,
   localparam int AW        = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cmd_valid,
   output logic                       cmd_ready,
   input  wire vfg_pkg::cmd_ctl_type  cmd_ctl,
   input  wire logic [DATA_BITS-1:0]  cmd_data,
   output logic                       mem_rd_en,
   output logic [AW-1:0]              mem_rd_addr,
   input  wire logic [DATA_BITS-1:0]  mem_rd_data,
   output logic                       flush_done,
   vfg_rsp_if.source                  rsp
);

   localparam int PB = vfg_pkg::CNT_MAX_BITS;
   localparam logic [PB-1:0] PTR_ONE = PB'(1);

   logic                 active_ff, active_in;
   logic                 delay_pend_ff, delay_pend_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic                 pend_last_ff, pend_last_in;
   logic [DATA_BITS-1:0] data_ff, data_in;
   logic                 seg_ff, seg_in;
   logic [PB-1:0]        ptr_ff, ptr_in;
   logic [PB-1:0]        stop_ff, stop_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0] out_data_ff, out_data_in;
   logic                 seg_end_ff, seg_end_in;
   logic                 last_ff, last_in;
   logic                 out_free, consumed;
   logic [PB-1:0]        ptr_nx;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_data    = out_data_ff;
   assign rsp.segment_end = seg_end_ff;
   assign rsp.last        = last_ff;
   assign cmd_ready       = !active_ff;
   assign mem_rd_addr     = ptr_ff[AW-1:0];
   assign ptr_nx          = ptr_ff + PTR_ONE;

   always_comb begin
      active_in     = active_ff;
      delay_pend_in = delay_pend_ff;
      rd_pend_in    = rd_pend_ff;
      pend_last_in  = pend_last_ff;
      data_in       = data_ff;
      seg_in        = seg_ff;
      ptr_in        = ptr_ff;
      stop_in       = stop_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_data_in   = out_data_ff;
      seg_end_in    = seg_end_ff;
      last_in       = last_ff;
      mem_rd_en     = 1'b0;
      flush_done    = 1'b0;
      consumed      = 1'b0;
      out_free      = !rsp_valid_ff || rsp.ready;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      // output register load: pending read data goes before a newer delayed word
      if (out_free) begin
         if (rd_pend_ff) begin
            rsp_valid_in = 1'b1;
            out_data_in  = mem_rd_data;
            seg_end_in   = 1'b0;
            last_in      = pend_last_ff;
            rd_pend_in   = 1'b0;
            consumed     = 1'b1;
         end else if (active_ff && delay_pend_ff) begin
            rsp_valid_in  = 1'b1;
            out_data_in   = data_ff;
            seg_end_in    = seg_ff;
            last_in       = !(ptr_ff < stop_ff);
            delay_pend_in = 1'b0;
            if (!(ptr_ff < stop_ff)) begin
               active_in = 1'b0;
            end
         end
      end

      // buffer read issue
      if (active_ff && !delay_pend_ff && (ptr_ff < stop_ff) && (!rd_pend_ff || consumed)) begin
         mem_rd_en    = 1'b1;
         ptr_in       = ptr_nx;
         rd_pend_in   = 1'b1;
         pend_last_in = (ptr_nx == stop_ff);
         if (ptr_nx == stop_ff) begin
            active_in  = 1'b0;
            flush_done = 1'b1;
         end
      end

      if (cmd_valid && !active_ff) begin
         active_in     = 1'b1;
         delay_pend_in = cmd_ctl.has_delay;
         data_in       = cmd_data;
         seg_in        = cmd_ctl.seg;
         ptr_in        = cmd_ctl.start;
         stop_in       = cmd_ctl.stop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         delay_pend_ff <= 1'b0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         active_ff     <= active_in;
         delay_pend_ff <= delay_pend_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_last_ff <= pend_last_in;
      data_ff      <= data_in;
      seg_ff       <= seg_in;
      ptr_ff       <= ptr_in;
      stop_ff      <= stop_in;
      out_data_ff  <= out_data_in;
      seg_end_ff   <= seg_end_in;
      last_ff      <= last_in;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/vad_frame_gate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vad_frame_gate
// Voice activity gate: holds frames from a speech trigger, flushes them on
// confirmation, passes confirmed speech with a one-frame delay for the
// segment end mark, and drops confirmed silence; when disabled it passes every frame.
// ----------------------------------------------------------------------------
// a passed or delayed word reaches the output register via the command queue and
//   the emitter's command registers; a flushed word via the hold RAM read register
// throughput: held frames 1 per cycle unless the input is stalled; passed frames
//   queue while there is room; a flush stalls the input until its last read issues
// reset: synchronous; phase silence, no held words, enabled 1, other front flags and
//   valid flags 0; data and hold buffer contents undefined, no clearing pass
module vad_frame_gate #(
   parameter int HOLD_DEPTH = vfg_pkg::HOLD_DEPTH_DEF,
   parameter int DATA_BITS  = vfg_pkg::DATA_BITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   vfg_req_if.sink     req_ch,
   vfg_rsp_if.source   rsp_ch,
   vfg_csr_if.sink     csr_ch
);

   localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
   localparam int QW = $bits(vfg_pkg::cmd_ctl_type) + DATA_BITS;

   logic                  mem_wr_en, mem_rd_en;
   logic [AW-1:0]         mem_wr_addr, mem_rd_addr;
   logic [DATA_BITS-1:0]  mem_wr_data, mem_rd_data;
   logic                  cmd_push, queue_full, flush_done;
   vfg_pkg::cmd_ctl_type  push_ctl, pop_ctl;
   logic [DATA_BITS-1:0]  push_data, pop_data;
   logic                  pop_valid, pop_ready;

   vfg_front #(.HOLD_DEPTH(HOLD_DEPTH), .DATA_BITS(DATA_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .csr         (csr_ch),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .cmd_push    (cmd_push),
      .cmd_ctl     (push_ctl),
      .cmd_data    (push_data),
      .queue_full  (queue_full),
      .flush_done  (flush_done)
   );

   vfg_queue #(.WIDTH(QW), .DEPTH(vfg_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data ({push_ctl, push_data}),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  ({pop_ctl, pop_data})
   );

   vfg_ram #(.WIDTH(DATA_BITS), .DEPTH(HOLD_DEPTH)) u_hold_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   vfg_back #(.HOLD_DEPTH(HOLD_DEPTH), .DATA_BITS(DATA_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (pop_valid),
      .cmd_ready   (pop_ready),
      .cmd_ctl     (pop_ctl),
      .cmd_data    (pop_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .flush_done  (flush_done),
      .rsp         (rsp_ch)
   );

endmodule
`default_nettype wire
